// ===== hw/rtl/wae_pkg.sv =====
// ----------------------------------------------------------------------------
// wae_pkg
// Shared types and fixed constants of the wrapped angle smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package wae_pkg;

   // sensor response word layout
   localparam int unsigned RAW_BITS = 16;
   localparam int unsigned ERR_POS  = 14;

   // smoothing factor: unsigned fraction over 2^FACTOR_BITS
   localparam int unsigned FACTOR_BITS = 16;
   localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 16'h4000;

   // input register contents handed to the datapath
   typedef struct packed {
      logic                valid;
      logic [RAW_BITS-1:0] word;
   } s1_type;

endpackage : wae_pkg

`default_nettype wire

// ===== hw/rtl/wae_if.sv =====
// ----------------------------------------------------------------------------
// wae channel interfaces
// Valid/ready channels for sensor words in and smoothed results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wae_req_if;
   import wae_pkg::*;

   logic                valid;
   logic                ready;
   logic [RAW_BITS-1:0] raw_word;

   modport source (output valid, output raw_word, input ready);
   modport sink   (input valid, input raw_word, output ready);
endinterface : wae_req_if

interface wae_rsp_if #(
   parameter int unsigned ANGLE_BITS = 14
);
   logic                  valid;
   logic                  ready;
   logic [ANGLE_BITS-1:0] smoothed_angle;
   logic [ANGLE_BITS-1:0] raw_angle;
   logic                  parity_ok;
   logic                  error_bit;

   modport source (output valid, output smoothed_angle, output raw_angle,
                   output parity_ok, output error_bit, input ready);
   modport sink   (input valid, input smoothed_angle, input raw_angle,
                   input parity_ok, input error_bit, output ready);
endinterface : wae_rsp_if

`default_nettype wire

// ===== hw/rtl/wae_front.sv =====
// ----------------------------------------------------------------------------
// wae_front
// Input register: captures one sensor word per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module wae_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [wae_pkg::RAW_BITS-1:0] req_word,
   input  wire logic                         advance,
   output      logic                         req_ready,
   output      wae_pkg::s1_type              s1
);
   import wae_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   logic [RAW_BITS-1:0] word_ff;
   logic                take;

   // the register frees up in the same cycle its word moves on
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= req_word;
      end
   end

   assign s1 = {valid_ff, word_ff};

endmodule : wae_front

`default_nettype wire

// ===== hw/rtl/wae_core.sv =====
// ----------------------------------------------------------------------------
// wae_core
// Estimate register, factor register and the unwrap/blend/round datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module wae_core #(
   parameter int unsigned ANGLE_BITS = 14,
   parameter int unsigned FRAC_BITS  = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire wae_pkg::s1_type                 s1,
   input  wire logic                            csr_we,
   input  wire logic [wae_pkg::FACTOR_BITS-1:0] csr_wdata,
   output      logic [ANGLE_BITS-1:0]           smoothed_angle
);
   import wae_pkg::*;

   localparam int unsigned W  = ANGLE_BITS + FRAC_BITS;
   localparam int unsigned PW = W + FACTOR_BITS + 2;

   localparam logic signed [W:0]    HalfPos  = {2'b01, {(W-1){1'b0}}};
   localparam logic signed [W:0]    HalfNeg  = {2'b11, {(W-1){1'b0}}};
   localparam logic signed [PW-1:0] RoundBias =
      {{(PW-FACTOR_BITS){1'b0}}, 1'b1, {(FACTOR_BITS-1){1'b0}}};

   logic [W-1:0]                est_ff;
   logic [W-1:0]                est_in;
   logic [FACTOR_BITS-1:0]      factor_ff;
   logic [W-1:0]                sample;
   logic signed [W:0]           diff;
   logic signed [W:0]           dwrap;
   logic signed [FACTOR_BITS:0] weight;
   logic signed [PW-1:0]        prod;
   logic signed [PW-1:0]        prod_rnd;
   logic [W-1:0]                step;

   assign sample = {s1.word[ANGLE_BITS-1:0], {FRAC_BITS{1'b0}}};
   assign diff   = $signed({1'b0, sample}) - $signed({1'b0, est_ff});

   // unwrap by one full range: +/-2^W is a flip of the top bit
   always_comb begin
      if (diff > HalfPos || diff < HalfNeg) begin
         dwrap = {~diff[W], diff[W-1:0]};
      end else begin
         dwrap = diff;
      end
   end

   // new = est + round((sample - est) * a / 2^16), kept modulo 2^W
   assign weight   = $signed({1'b0, factor_ff});
   assign prod     = PW'(dwrap) * PW'(weight);
   assign prod_rnd = prod + RoundBias;
   assign step     = prod_rnd[W+FACTOR_BITS-1:FACTOR_BITS];
   assign est_in   = est_ff + step;

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff    <= '0;
         factor_ff <= FACTOR_RESET;
      end else begin
         if (advance) begin
            est_ff <= est_in;
         end
         if (csr_we) begin
            factor_ff <= csr_wdata;
         end
      end
   end

   // round half up to whole tics, wraps with the angle width
   assign smoothed_angle = est_in[W-1:FRAC_BITS] + ANGLE_BITS'(est_in[FRAC_BITS-1]);

endmodule : wae_core

`default_nettype wire

// ===== hw/rtl/wrapped_angle_exp_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// wrapped_angle_exp_smoother_unit
// Parity/flag check and circular exponential smoothing of sensor angles.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake      | payload
//  req_chan  | in  | valid / ready  | raw_word[15:0]
//  rsp_chan  | out | valid / ready  | smoothed_angle, raw_angle, parity_ok, error_bit
//  csr       | in  | csr_we         | csr_wdata[15:0] smoothing factor
//
//  One beat in and one beat out per cycle while the result sink keeps ready
//  high; an accepted word passes through the input register and then the
//  result register, from which its result beat is taken. The estimate update
//  (subtract, unwrap, 31x17 multiply, round, add) closes in the cycle the word
//  leaves the input register. Reset clears both valid flags, the estimate and
//  loads the factor with 16384. A stalled result holds and backs up the input
//  register; a new word is still taken while the result register waits only
//  if the input register is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module wrapped_angle_exp_smoother_unit #(
   parameter int unsigned ANGLE_BITS = 14,
   parameter int unsigned FRAC_BITS  = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   wae_req_if.sink                              req_chan,
   wae_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [wae_pkg::FACTOR_BITS-1:0] csr_wdata
);
   import wae_pkg::*;

   s1_type                s1;
   logic                  advance;
   logic                  req_ready;
   logic [ANGLE_BITS-1:0] smoothed;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [ANGLE_BITS-1:0] smoothed_ff;
   logic [ANGLE_BITS-1:0] raw_angle_ff;
   logic                  parity_ok_ff;
   logic                  error_bit_ff;

   assign advance = s1.valid && (!rsp_valid_ff || rsp_chan.ready);

   wae_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_word  (req_chan.raw_word),
      .advance   (advance),
      .req_ready (req_ready),
      .s1        (s1)
   );

   wae_core #(
      .ANGLE_BITS (ANGLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .s1             (s1),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .smoothed_angle (smoothed)
   );

   assign req_chan.ready = req_ready;

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         smoothed_ff  <= smoothed;
         raw_angle_ff <= s1.word[ANGLE_BITS-1:0];
         parity_ok_ff <= ~^s1.word;
         error_bit_ff <= s1.word[ERR_POS];
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.smoothed_angle = smoothed_ff;
   assign rsp_chan.raw_angle      = raw_angle_ff;
   assign rsp_chan.parity_ok      = parity_ok_ff;
   assign rsp_chan.error_bit      = error_bit_ff;

`ifndef SYNTHESIS
   // a word waiting behind a stalled result stays put
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1.valid && rsp_valid_ff && !rsp_chan.ready) |=> (s1.valid && $stable(s1.word)))
      else $error("input register changed while result stalled");

   // every accepted beat lands in the input register
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s1.valid)
      else $error("accepted beat lost");

   // a word that moves on always produces a result
   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced word gave no result");

   // results only appear after a word moved on
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result without a source word");
`endif

endmodule : wrapped_angle_exp_smoother_unit

`default_nettype wire

// ===== verif/wae_smoother_check.sv =====
// ----------------------------------------------------------------------------
// wae_smoother_check
// Watches the sensor word and result channels plus the factor register
// writes, keeps its own copy of the circular smoothing estimate and compares
// every result beat field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module wae_smoother_check (
   input  wire logic                            clock,
   input  wire logic                            reset,
   wae_req_if                                   req_mon,
   wae_rsp_if                                   rsp_mon,
   input  wire logic                            csr_we,
   input  wire logic [wae_pkg::FACTOR_BITS-1:0] csr_wdata,
   output int                                   mismatches,
   output int                                   outstanding,
   output int                                   unwraps
);
   import wae_pkg::*;

   localparam int unsigned ANGLE_W   = 14;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned PRINT_CAP = 30;

   localparam longint unsigned EST_MOD    = 64'd1 << (ANGLE_W + FRAC_W);
   localparam longint unsigned EST_MASK   = EST_MOD - 64'd1;
   localparam longint unsigned HALF_FIX   = 64'd1 << (ANGLE_W - 1 + FRAC_W);
   localparam longint unsigned HALF_TIC   = 64'd1 << (FRAC_W - 1);
   localparam longint unsigned WEIGHT_ONE = 64'd1 << FACTOR_BITS;

   typedef struct packed {
      logic [ANGLE_W-1:0] smoothed_angle;
      logic [ANGLE_W-1:0] raw_angle;
      logic               parity_ok;
      logic               error_bit;
   } angle_result_type;

   logic [ANGLE_W+FRAC_W-1:0] est_fix = '0;
   logic [FACTOR_BITS-1:0]    factor  = FACTOR_RESET;
   angle_result_type          pending_angles[$];
   int                        fail_count = 0;
   int                        wrap_count = 0;

   initial begin
      mismatches  = 0;
      outstanding = 0;
      unwraps     = 0;
   end

   // advances the estimate by one sensor word and returns the result it yields
   function automatic angle_result_type smooth_sample(input logic [RAW_BITS-1:0] word);
      angle_result_type r;
      longint unsigned  e_fix;
      longint unsigned  s_fix;
      longint unsigned  s_off;
      longint unsigned  blend;
      longint unsigned  rounded;
      e_fix = est_fix;
      s_fix = word[ANGLE_W-1:0];
      s_fix = s_fix << FRAC_W;
      // sample offset by one range so the blend never goes negative
      if (e_fix > s_fix && e_fix - s_fix > HALF_FIX) begin
         s_off = s_fix + 2 * EST_MOD;
         wrap_count++;
      end else if (s_fix > e_fix && s_fix - e_fix > HALF_FIX) begin
         s_off = s_fix;
         wrap_count++;
      end else begin
         s_off = s_fix + EST_MOD;
      end
      blend   = (e_fix + EST_MOD) * (WEIGHT_ONE - factor) + s_off * factor;
      e_fix   = ((blend + 64'd32768) >> FACTOR_BITS) & EST_MASK;
      est_fix = e_fix[ANGLE_W+FRAC_W-1:0];
      rounded = (e_fix + HALF_TIC) >> FRAC_W;
      r.smoothed_angle = rounded[ANGLE_W-1:0];
      r.raw_angle      = word[ANGLE_W-1:0];
      r.parity_ok      = ~(^word);
      r.error_bit      = word[ERR_POS];
      return r;
   endfunction

   task automatic report_field(input string field, input int want, input int seen);
      if (want != seen) begin
         fail_count++;
         if (fail_count <= PRINT_CAP) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
         end
      end
   endtask

   always @(posedge clock) begin
      angle_result_type want;
      angle_result_type seen;
      if (reset) begin
         est_fix    = '0;
         factor     = FACTOR_RESET;
         wrap_count = 0;
         pending_angles.delete();
      end else begin
         if (csr_we) begin
            factor = csr_wdata;
         end
         // retire before predicting: a result never belongs to a word taken this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.smoothed_angle = rsp_mon.smoothed_angle;
            seen.raw_angle      = rsp_mon.raw_angle;
            seen.parity_ok      = rsp_mon.parity_ok;
            seen.error_bit      = rsp_mon.error_bit;
            if (pending_angles.size() == 0) begin
               fail_count++;
               if (fail_count <= PRINT_CAP) begin
                  $display("%0t: result beat with nothing expected, expected none, actual %0d",
                           $time, seen.smoothed_angle);
               end
            end else begin
               want = pending_angles.pop_front();
               report_field("smoothed_angle", want.smoothed_angle, seen.smoothed_angle);
               report_field("raw_angle", want.raw_angle, seen.raw_angle);
               report_field("parity_ok", want.parity_ok, seen.parity_ok);
               report_field("error_bit", want.error_bit, seen.error_bit);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_angles.push_back(smooth_sample(req_mon.raw_word));
         end
      end
      outstanding <= pending_angles.size();
      unwraps     <= wrap_count;
      mismatches  <= fail_count;
   end

endmodule : wae_smoother_check

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives sensor words in bursts against a stalling result sink, steps the
// smoothing factor through its extremes between drained phases and reports
// the verdict from the checker's failure count and its outstanding results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import wae_pkg::*;

   localparam int unsigned STALL_LIMIT     = 2000;
   localparam int unsigned WORDS_PER_PHASE = 230;
   localparam int unsigned TAIL_CYCLES     = 8;

   // reset factor: quiet words at angle 0, then a jump of exactly half the range
   localparam logic [15:0] WORDS_RESET_FACTOR [5] = '{
      16'h0000, 16'h8000, 16'h4000, 16'hC000, 16'h2000
   };
   // half weight: unwrap downward, exact half-range both ways, field extremes
   localparam logic [15:0] WORDS_HALF_FACTOR [10] = '{
      16'h3800, 16'h2000, 16'h3000, 16'h0000, 16'h3FFF,
      16'hFFFF, 16'h7FFF, 16'hBFFF, 16'h5555, 16'hAAAA
   };
   // zero weight: estimate must hold
   localparam logic [15:0] WORDS_ZERO_FACTOR [3] = '{16'h0001, 16'h3FFF, 16'h9234};
   // full weight: follow the sample across the wrap point
   localparam logic [15:0] WORDS_FULL_FACTOR [5] = '{
      16'h3FFF, 16'h0000, 16'h2000, 16'h0001, 16'h3FFE
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [FACTOR_BITS-1:0] csr_wdata;

   int          mismatches;
   int          outstanding;
   int          unwraps;
   int unsigned burst_left    = 0;
   int unsigned words_sent    = 0;
   int unsigned factor_writes = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned ready_hold    = 0;
   logic [13:0] last_angle    = '0;

   wae_req_if                   req_chan ();
   wae_rsp_if #(.ANGLE_BITS(14)) rsp_chan ();

   wrapped_angle_exp_smoother_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   wae_smoother_check angle_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .unwraps     (unwraps)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // sink: long ready stretches, mostly short stalls, now and then a long one
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_chan.ready <= ~rsp_chan.ready;
         if (rsp_chan.ready) begin
            ready_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                      : $urandom_range(0, 3);
         end else begin
            ready_hold <= $urandom_range(0, 40);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("no beat for %0d cycles, giving up", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // mostly well-formed words, biased toward the wrap point and half-range jumps
   function automatic logic [15:0] random_word();
      logic [13:0] angle;
      logic        err;
      logic        par;
      case ($urandom_range(0, 7))
         0: begin
            angle = 14'($urandom_range(0, 15));
         end
         1: begin
            angle = 14'(16383 - $urandom_range(0, 15));
         end
         2: begin
            angle = last_angle + 14'(8189 + $urandom_range(0, 6));
         end
         default: begin
            angle = 14'($urandom_range(0, 16383));
         end
      endcase
      err        = ($urandom_range(0, 7) == 0);
      par        = ($urandom_range(0, 3) == 0) ? 1'($urandom) : ^{err, angle};
      last_angle = angle;
      return {par, err, angle};
   endfunction

   task automatic send_word(input logic [15:0] word);
      int unsigned pause;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         pause      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (pause != 0) begin
            req_chan.valid <= 1'b0;
            repeat (pause) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid    <= 1'b1;
      req_chan.raw_word <= word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_factor(input logic [FACTOR_BITS-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      factor_writes++;
   endtask

   task automatic random_phase(input logic [FACTOR_BITS-1:0] value);
      set_factor(value);
      repeat (WORDS_PER_PHASE) send_word(random_word());
   endtask

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.raw_word = '0;
      rsp_chan.ready    = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (WORDS_RESET_FACTOR[i]) send_word(WORDS_RESET_FACTOR[i]);
      set_factor(16'd32768);
      foreach (WORDS_HALF_FACTOR[i]) send_word(WORDS_HALF_FACTOR[i]);
      set_factor(16'd0);
      foreach (WORDS_ZERO_FACTOR[i]) send_word(WORDS_ZERO_FACTOR[i]);
      set_factor(16'd65535);
      foreach (WORDS_FULL_FACTOR[i]) send_word(WORDS_FULL_FACTOR[i]);

      random_phase(16'($urandom_range(1, 65534)));
      random_phase(16'd1);
      random_phase(16'd65535);
      random_phase(16'd32768);
      random_phase(16'($urandom_range(0, 255)));
      random_phase(16'd0);
      random_phase(16'($urandom_range(49152, 65535)));
      random_phase(FACTOR_RESET);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d sensor words over %0d factor settings plus the reset value",
               words_sent, factor_writes);
      $display("%0d samples crossed the wrap point and were unwrapped", unwraps);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches, outstanding);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule : tb

`default_nettype wire
